// ===== rtl/core/stepper_half_step_sequencer_macros.svh =====
// Assertion helpers for the half-step sequencer.
// Both forms sample on clk and are disabled while rst_n is low.
`ifndef STEPPER_HALF_STEP_SEQUENCER_MACROS_SVH
`define STEPPER_HALF_STEP_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

`define SHS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shs same-cycle check failed");

`define SHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shs next-cycle check failed");

`else

`define SHS_ASSERT_NOW(lbl, ante, cons)
`define SHS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/shs_pkg.sv =====
package shs_pkg;

  localparam int unsigned PHASE_COUNT = 8;
  localparam int unsigned PHASE_W     = 3;
  localparam int unsigned POS_W       = 9;
  localparam int unsigned STEP_W      = 16;

  localparam logic [3:0] COILS_OFF = 4'hF;
  localparam logic [POS_W-1:0] MAX_POS_RESET = 9'd500;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_MOVE = 2'd1,
    OP_STOP = 2'd2,
    OP_HOLD = 2'd3
  } op_t;

  // Active-low half-step patterns, bit0 = IN1.
  localparam logic [3:0] PHASE_TABLE [PHASE_COUNT] = '{
    4'hE, 4'hC, 4'hD, 4'h9, 4'hB, 4'h3, 4'h7, 4'h6
  };

endpackage

// ===== rtl/core/stepper_half_step_sequencer.sv =====
// Half-step sequencer for a four-coil stepper, one result per transaction.
// out_valid is registered and rises in the cycle after input acceptance.
// Throughput: 1 transaction per cycle; the state update and result register
// share one clock edge, so in_stall rises only while a held result is stalled.
// Reset (rst_n low, synchronous): idle, position 0, phase 0, coils 0xE,
// max_position 500, no result pending.
`include "stepper_half_step_sequencer_macros.svh"

module stepper_half_step_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_opcode,
  input  logic signed [shs_pkg::STEP_W-1:0] in_step_request,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [3:0]                      out_coil_pattern,
  output logic                            out_coils_written,
  output logic                            out_moving,
  output logic                            out_closing,
  output logic [shs_pkg::POS_W-1:0]       out_position,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [shs_pkg::POS_W-1:0]       cfg_max_position
);

  logic [shs_pkg::POS_W-1:0]   max_pos_r;
  logic [shs_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic                        active_r, active_nxt;
  logic                        close_r, close_nxt;
  logic [shs_pkg::STEP_W-1:0]  done_r, done_nxt;
  logic [shs_pkg::STEP_W-1:0]  wanted_r, wanted_nxt;
  logic [shs_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [3:0]                  coil_r, coil_nxt;
  logic                        wrote_r, wrote_nxt;
  logic                        out_valid_r;

  logic                        in_accept;
  logic                        end_stop;
  logic [shs_pkg::POS_W:0]     pos_inc;
  logic [shs_pkg::STEP_W:0]    want_mag;
  logic [shs_pkg::STEP_W-1:0]  done_inc;
  logic [shs_pkg::PHASE_W-1:0] phase_step;
  shs_pkg::op_t                op;

  assign op        = shs_pkg::op_t'(in_opcode);
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign end_stop = (close_r && (pos_r == '0)) || (!close_r && (pos_r >= max_pos_r));
  assign pos_inc  = {1'b0, pos_r} + {{shs_pkg::POS_W{1'b0}}, 1'b1};
  assign done_inc = done_r + {{(shs_pkg::STEP_W-1){1'b0}}, 1'b1};
  // magnitude of the stored two's complement request; 0x8000 gives 32768
  assign want_mag = wanted_r[shs_pkg::STEP_W-1]
                  ? ({1'b1, {shs_pkg::STEP_W{1'b0}}} - {1'b0, wanted_r})
                  : {1'b0, wanted_r};
  assign phase_step = close_r ? (phase_r - {{(shs_pkg::PHASE_W-1){1'b0}}, 1'b1})
                              : (phase_r + {{(shs_pkg::PHASE_W-1){1'b0}}, 1'b1});

  always_comb begin
    phase_nxt  = phase_r;
    active_nxt = active_r;
    close_nxt  = close_r;
    done_nxt   = done_r;
    wanted_nxt = wanted_r;
    pos_nxt    = pos_r;
    coil_nxt   = coil_r;
    wrote_nxt  = 1'b0;
    case (op)
      shs_pkg::OP_TICK: begin
        if (end_stop) begin
          active_nxt = 1'b0;
          coil_nxt   = shs_pkg::COILS_OFF;
          wrote_nxt  = 1'b1;
        end else if (active_r && (wanted_r != '0)) begin
          phase_nxt = phase_step;
          if (close_r) begin
            if (pos_r != '0) pos_nxt = pos_r - {{(shs_pkg::POS_W-1){1'b0}}, 1'b1};
          end else begin
            if (pos_inc <= {1'b0, max_pos_r}) pos_nxt = pos_inc[shs_pkg::POS_W-1:0];
          end
          coil_nxt  = shs_pkg::PHASE_TABLE[phase_step];
          done_nxt  = done_inc;
          if ({1'b0, done_inc} >= want_mag) active_nxt = 1'b0;
          wrote_nxt = 1'b1;
        end
      end
      shs_pkg::OP_MOVE: begin
        wanted_nxt = in_step_request;
        done_nxt   = '0;
        close_nxt  = !in_step_request[shs_pkg::STEP_W-1];
        if (in_step_request != '0) active_nxt = 1'b1;
      end
      shs_pkg::OP_STOP: begin
        active_nxt = 1'b0;
        coil_nxt   = shs_pkg::COILS_OFF;
        wrote_nxt  = 1'b1;
      end
      default: begin
        active_nxt = 1'b0;
        coil_nxt   = shs_pkg::PHASE_TABLE[phase_r];
        wrote_nxt  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pos_r   <= shs_pkg::MAX_POS_RESET;
      phase_r     <= '0;
      active_r    <= 1'b0;
      close_r     <= 1'b0;
      done_r      <= '0;
      wanted_r    <= '0;
      pos_r       <= '0;
      coil_r      <= shs_pkg::PHASE_TABLE[0];
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) max_pos_r <= cfg_max_position;
      if (in_accept) begin
        phase_r  <= phase_nxt;
        active_r <= active_nxt;
        close_r  <= close_nxt;
        done_r   <= done_nxt;
        wanted_r <= wanted_nxt;
        pos_r    <= pos_nxt;
        coil_r   <= coil_nxt;
      end
      if (in_accept) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // coils_written belongs to the held result only
  always_ff @(posedge clk) begin
    if (in_accept) wrote_r <= wrote_nxt;
  end

  // state registers double as the result payload: they change only on acceptance
  assign out_valid         = out_valid_r;
  assign out_coil_pattern  = coil_r;
  assign out_coils_written = wrote_r;
  assign out_moving        = active_r;
  assign out_closing       = close_r;
  assign out_position      = pos_r;

  `SHS_ASSERT_NOW(a_stall_needs_result, in_stall, out_valid)
  `SHS_ASSERT_NEXT(a_stop_turns_off, in_accept && (op == shs_pkg::OP_STOP),
                   out_valid && (out_coil_pattern == shs_pkg::COILS_OFF) &&
                   !out_moving && out_coils_written)
  `SHS_ASSERT_NEXT(a_move_no_coil_write, in_accept && (op == shs_pkg::OP_MOVE),
                   out_valid && !out_coils_written)
  `SHS_ASSERT_NEXT(a_hold_stops_motion, in_accept && (op == shs_pkg::OP_HOLD),
                   !out_moving && out_coils_written)

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [3:0]                coils;
    logic                      wrote;
    logic                      moving;
    logic                      closing;
    logic [shs_pkg::POS_W-1:0] pos;
  } drive_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic [1:0]                 in_opcode = shs_pkg::OP_TICK;
  logic [shs_pkg::STEP_W-1:0] in_step_request = '0;
  logic                       out_stall = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic [shs_pkg::POS_W-1:0]  cfg_max_position = shs_pkg::MAX_POS_RESET;
  wire                        in_stall;
  wire                        out_valid;
  wire [3:0]                  out_coil_pattern;
  wire                        out_coils_written;
  wire                        out_moving;
  wire                        out_closing;
  wire [shs_pkg::POS_W-1:0]   out_position;
  wire                        cfg_ready;

  // motor state as the sequencer should track it
  logic [shs_pkg::PHASE_W-1:0] m_phase;
  logic                        m_run;
  logic                        m_close;
  logic [shs_pkg::STEP_W-1:0]  m_done;
  logic [shs_pkg::STEP_W-1:0]  m_goal;
  logic [shs_pkg::POS_W-1:0]   m_pos;
  logic [shs_pkg::POS_W-1:0]   m_limit;
  logic [3:0]                  m_coils;

  drive_t pending_drives[$];
  int     mismatches = 0;
  int     items_sent = 0;
  bit     jitter = 1'b1;
  bit     hold_req = 1'b0;

  stepper_half_step_sequencer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_step_request  (in_step_request),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_coil_pattern (out_coil_pattern),
    .out_coils_written(out_coils_written),
    .out_moving       (out_moving),
    .out_closing      (out_closing),
    .out_position     (out_position),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_position (cfg_max_position)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic drive_t step_motor(input shs_pkg::op_t op,
                                        input logic [shs_pkg::STEP_W-1:0] req);
    drive_t       r;
    logic         wrote;
    logic [16:0]  goal;
    wrote = 1'b0;
    case (op)
      shs_pkg::OP_TICK: begin
        if ((m_close && m_pos == 0) || (!m_close && m_pos >= m_limit)) begin
          m_run = 1'b0;
          m_coils = shs_pkg::COILS_OFF;
          wrote = 1'b1;
        end else if (m_run && m_goal != 0) begin
          if (m_close) begin
            m_phase = m_phase - 1'b1;
            if (m_pos > 0) m_pos = m_pos - 1'b1;
          end else begin
            m_phase = m_phase + 1'b1;
            if (m_pos + 1 <= m_limit) m_pos = m_pos + 1'b1;
          end
          m_coils = shs_pkg::PHASE_TABLE[m_phase];
          m_done = m_done + 1'b1;
          goal = m_goal[shs_pkg::STEP_W-1] ? 17'h10000 - {1'b0, m_goal} : {1'b0, m_goal};
          if ({1'b0, m_done} >= goal) m_run = 1'b0;
          wrote = 1'b1;
        end
      end
      shs_pkg::OP_MOVE: begin
        m_goal = req;
        m_done = '0;
        m_close = !req[shs_pkg::STEP_W-1];
        if (req != 0) m_run = 1'b1;
      end
      shs_pkg::OP_STOP: begin
        m_run = 1'b0;
        m_coils = shs_pkg::COILS_OFF;
        wrote = 1'b1;
      end
      default: begin
        m_run = 1'b0;
        m_coils = shs_pkg::PHASE_TABLE[m_phase];
        wrote = 1'b1;
      end
    endcase
    r.coils = m_coils;
    r.wrote = wrote;
    r.moving = m_run;
    r.closing = m_close;
    r.pos = m_pos;
    return r;
  endfunction

  always @(posedge clk) begin : check_drive
    drive_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_drives.size() == 0) begin
        $error("unexpected transaction: coil_pattern %h position %0d",
               out_coil_pattern, out_position);
        mismatches++;
      end else begin
        e = pending_drives.pop_front();
        if (out_coil_pattern !== e.coils) begin
          $error("coil_pattern: expected %h, got %h", e.coils, out_coil_pattern);
          mismatches++;
        end
        if (out_coils_written !== e.wrote) begin
          $error("coils_written: expected %b, got %b", e.wrote, out_coils_written);
          mismatches++;
        end
        if (out_moving !== e.moving) begin
          $error("moving: expected %b, got %b", e.moving, out_moving);
          mismatches++;
        end
        if (out_closing !== e.closing) begin
          $error("closing: expected %b, got %b", e.closing, out_closing);
          mismatches++;
        end
        if (out_position !== e.pos) begin
          $error("position: expected %0d, got %0d", e.pos, out_position);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : drive_out_stall
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (n = 0; n < 48; n++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (jitter && rst_n && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic offer_cmd(input shs_pkg::op_t op, input logic [shs_pkg::STEP_W-1:0] req);
    if (jitter && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_step_request <= req;
    do @(posedge clk); while (in_stall);
    pending_drives.push_back(step_motor(op, req));
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_travel_limit(input logic [shs_pkg::POS_W-1:0] lim);
    cfg_valid <= 1'b1;
    cfg_max_position <= lim;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_limit = lim;
  endtask

  task automatic test_idle_and_commands();
    offer_cmd(shs_pkg::OP_TICK, 16'h7FFF);
    offer_cmd(shs_pkg::OP_HOLD, 16'h8000);
    offer_cmd(shs_pkg::OP_STOP, 16'hFFFF);
    offer_cmd(shs_pkg::OP_MOVE, 16'h0000);
    offer_cmd(shs_pkg::OP_TICK, 16'h0000);
    offer_cmd(shs_pkg::OP_MOVE, shs_pkg::STEP_W'(-3));
    repeat (4) offer_cmd(shs_pkg::OP_TICK, 16'h5555);
    offer_cmd(shs_pkg::OP_MOVE, shs_pkg::STEP_W'(2));
    repeat (3) offer_cmd(shs_pkg::OP_TICK, 16'hAAAA);
    offer_cmd(shs_pkg::OP_MOVE, 16'h8000);
    repeat (2) offer_cmd(shs_pkg::OP_TICK, 16'h0000);
    offer_cmd(shs_pkg::OP_HOLD, 16'h0000);
    offer_cmd(shs_pkg::OP_TICK, 16'h0000);
    offer_cmd(shs_pkg::OP_MOVE, 16'h7FFF);
    offer_cmd(shs_pkg::OP_TICK, 16'h0000);
    offer_cmd(shs_pkg::OP_MOVE, 16'h0000);
    offer_cmd(shs_pkg::OP_TICK, 16'h0000);
    offer_cmd(shs_pkg::OP_STOP, 16'h0000);
    offer_cmd(shs_pkg::OP_MOVE, 16'hFFFF);
    repeat (2) offer_cmd(shs_pkg::OP_TICK, 16'hFFFF);
  endtask

  task automatic test_end_stops();
    settle();
    set_travel_limit(9'd1);
    offer_cmd(shs_pkg::OP_MOVE, shs_pkg::STEP_W'(-5));
    repeat (4) offer_cmd(shs_pkg::OP_TICK, 16'h0000);
    offer_cmd(shs_pkg::OP_MOVE, shs_pkg::STEP_W'(5));
    repeat (6) offer_cmd(shs_pkg::OP_TICK, 16'h0000);
    settle();
    set_travel_limit(9'd20);
    offer_cmd(shs_pkg::OP_MOVE, shs_pkg::STEP_W'(-30));
    repeat (25) offer_cmd(shs_pkg::OP_TICK, 16'h0000);
    settle();
    // position now sits above the new limit
    set_travel_limit(9'd5);
    offer_cmd(shs_pkg::OP_MOVE, shs_pkg::STEP_W'(-3));
    offer_cmd(shs_pkg::OP_TICK, 16'h0000);
    offer_cmd(shs_pkg::OP_MOVE, shs_pkg::STEP_W'(2));
    repeat (3) offer_cmd(shs_pkg::OP_TICK, 16'h0000);
  endtask

  task automatic test_long_travel();
    settle();
    set_travel_limit(9'd511);
    offer_cmd(shs_pkg::OP_MOVE, shs_pkg::STEP_W'(-270));
    repeat (270) offer_cmd(shs_pkg::OP_TICK, shs_pkg::STEP_W'($urandom));
    offer_cmd(shs_pkg::OP_MOVE, shs_pkg::STEP_W'(8));
    repeat (8) offer_cmd(shs_pkg::OP_TICK, shs_pkg::STEP_W'($urandom));
  endtask

  task automatic test_backpressure();
    settle();
    jitter = 1'b0;
    hold_req = 1'b1;
    offer_cmd(shs_pkg::OP_MOVE, shs_pkg::STEP_W'(-12));
    repeat (14) offer_cmd(shs_pkg::OP_TICK, 16'h0000);
    offer_cmd(shs_pkg::OP_HOLD, 16'h0000);
    offer_cmd(shs_pkg::OP_MOVE, shs_pkg::STEP_W'(10));
    repeat (12) offer_cmd(shs_pkg::OP_TICK, 16'h0000);
    offer_cmd(shs_pkg::OP_STOP, 16'h0000);
    settle();
    jitter = 1'b1;
  endtask

  task automatic test_random_walks(input int phases, input int per_phase);
    int                         stop_at;
    int                         mag;
    int                         len;
    logic [shs_pkg::STEP_W-1:0] req;
    for (int p = 0; p < phases; p++) begin
      settle();
      case (p % 4)
        0: set_travel_limit(shs_pkg::POS_W'($urandom_range(2, 40)));
        1: set_travel_limit(9'd1);
        2: set_travel_limit(9'd511);
        default: set_travel_limit(shs_pkg::POS_W'($urandom_range(2, 510)));
      endcase
      jitter = (p % 3 != 2) && (p != phases - 1);
      stop_at = items_sent + per_phase;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 9) < 7) begin
          mag = $urandom_range(1, 24);
          req = $urandom_range(0, 1) ? shs_pkg::STEP_W'(-mag) : shs_pkg::STEP_W'(mag);
          offer_cmd(shs_pkg::OP_MOVE, req);
          len = mag + $urandom_range(0, 3);
          for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 19))
              0: offer_cmd(shs_pkg::OP_STOP, shs_pkg::STEP_W'($urandom));
              1: offer_cmd(shs_pkg::OP_HOLD, shs_pkg::STEP_W'($urandom));
              default: offer_cmd(shs_pkg::OP_TICK, shs_pkg::STEP_W'($urandom));
            endcase
          end
        end else begin
          offer_cmd(shs_pkg::op_t'($urandom_range(0, 3)), shs_pkg::STEP_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    m_phase = '0;
    m_run = 1'b0;
    m_close = 1'b0;
    m_done = '0;
    m_goal = '0;
    m_pos = '0;
    m_limit = shs_pkg::MAX_POS_RESET;
    m_coils = shs_pkg::PHASE_TABLE[0];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_and_commands();
    test_end_stops();
    test_long_travel();
    test_backpressure();
    test_random_walks(5, 120);
    settle();
    if (mismatches == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
